>>> hw/rtl/keyframe_linear_interpolator_macros.svh
// ----------------------------------------------------------------------------
// Keyframe linear interpolator assertion macros
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_MACROS_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define KLI_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define KLI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define KLI_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define KLI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

>>> hw/rtl/kli_pkg.sv
// ----------------------------------------------------------------------------
// Keyframe linear interpolator package
// Sizes, codes and the command/status structs shared by the block's modules.
// ----------------------------------------------------------------------------
package kli_pkg;

   localparam int MAX_POINTS  = 64;
   localparam int ATOMS       = 4;
   localparam int WEIGHT_BITS = 16;

   // fixed field widths
   localparam int ATOM_FIELDS = 4;
   localparam int ATOM_W      = 32;
   localparam int TIME_W      = 32;
   localparam int SLOT_W      = 6;
   localparam int PCOUNT_W    = 7;
   localparam int STATUS_W    = 3;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 8;

   // derived sizes
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int ATOM_IDX_W = (ATOMS > 1) ? $clog2(ATOMS) : 1;
   localparam int STEP_W     = $clog2(WEIGHT_BITS);
   localparam int DIFF_W     = ATOM_W + 1;
   localparam int PROD_W     = DIFF_W + WEIGHT_BITS + 1;
   localparam int SUM_W      = PROD_W + 1;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ATOM_IS_INT = CSR_IDX_W'(1);

   typedef enum logic [STATUS_W-1:0] {
      ST_INTERP = 3'd0,
      ST_HOLD   = 3'd1,
      ST_AFTER  = 3'd2,
      ST_BEFORE = 3'd3,
      ST_EMPTY  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_START,
      SEL_END,
      SEL_WORK
   } out_sel_type;

   typedef struct packed {
      logic [TIME_W-1:0]             tstamp;
      logic                          hold;
      logic [ATOMS-1:0][ATOM_W-1:0]  atoms;
   } row_type;

   typedef struct packed {
      logic                               func;
      logic [SLOT_W-1:0]                  point_index;
      logic [TIME_W-1:0]                  point_time;
      logic                               point_mode;
      logic [ATOM_FIELDS-1:0][ATOM_W-1:0] atoms;
      logic [TIME_W-1:0]                  query_time;
   } req_payload_type;

   typedef struct packed {
      logic                  wr_en;
      logic                  rd_en;
      logic [IDX_W-1:0]      rd_addr;
      logic                  load_query;
      logic                  load_prev;
      logic                  load_cur;
      logic                  div_init;
      logic                  div_step;
      logic                  mul_en;
      logic                  acc_en;
      logic [ATOM_IDX_W-1:0] atom_sel;
      logic                  out_load;
      out_sel_type           out_sel;
      status_type            out_status;
   } dp_cmd_type;

   typedef struct packed {
      logic later;
      logic prev_hold;
   } dp_stat_type;

endpackage

>>> hw/rtl/kli_req_if.sv
// ----------------------------------------------------------------------------
// Keyframe interpolator request channel
// Valid/ready channel carrying keyframe writes and value queries.
// ----------------------------------------------------------------------------
interface kli_req_if;

   logic                             valid;
   logic                             ready;
   logic                             func;
   logic [kli_pkg::SLOT_W-1:0]       point_index;
   logic [kli_pkg::TIME_W-1:0]       point_time;
   logic                             point_mode;
   logic signed [kli_pkg::ATOM_W-1:0] atom_in0;
   logic signed [kli_pkg::ATOM_W-1:0] atom_in1;
   logic signed [kli_pkg::ATOM_W-1:0] atom_in2;
   logic signed [kli_pkg::ATOM_W-1:0] atom_in3;
   logic [kli_pkg::TIME_W-1:0]       query_time;

   modport source (
      output valid, func, point_index, point_time, point_mode,
             atom_in0, atom_in1, atom_in2, atom_in3, query_time,
      input  ready
   );

   modport sink (
      input  valid, func, point_index, point_time, point_mode,
             atom_in0, atom_in1, atom_in2, atom_in3, query_time,
      output ready
   );

endinterface

>>> hw/rtl/kli_rsp_if.sv
// ----------------------------------------------------------------------------
// Keyframe interpolator response channel
// Valid/ready channel carrying the atoms and status of one query.
// ----------------------------------------------------------------------------
interface kli_rsp_if;

   logic                              valid;
   logic                              ready;
   logic signed [kli_pkg::ATOM_W-1:0] atom_out0;
   logic signed [kli_pkg::ATOM_W-1:0] atom_out1;
   logic signed [kli_pkg::ATOM_W-1:0] atom_out2;
   logic signed [kli_pkg::ATOM_W-1:0] atom_out3;
   logic [kli_pkg::STATUS_W-1:0]      status;

   modport source (
      output valid, atom_out0, atom_out1, atom_out2, atom_out3, status,
      input  ready
   );

   modport sink (
      input  valid, atom_out0, atom_out1, atom_out2, atom_out3, status,
      output ready
   );

endinterface

>>> hw/rtl/kli_csr_if.sv
// ----------------------------------------------------------------------------
// Keyframe interpolator register write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface kli_csr_if;

   logic                           valid;
   logic                           ready;
   logic [kli_pkg::CSR_IDX_W-1:0]  index;
   logic [kli_pkg::CSR_DATA_W-1:0] data;

   modport source (
      output valid, index, data,
      input  ready
   );

   modport sink (
      input  valid, index, data,
      output ready
   );

endinterface

>>> hw/rtl/kli_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kli_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/kli_ctrl.sv
// ----------------------------------------------------------------------------
// Keyframe interpolator controller
// Sequences the keyframe scan, weight division and per-atom blend, holds the
// register file and the response valid flag.
// ----------------------------------------------------------------------------
`include "keyframe_linear_interpolator_macros.svh"

module kli_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_func,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   kli_csr_if.sink              csr_if,
   input  kli_pkg::dp_stat_type stat,
   output kli_pkg::dp_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DIV_INIT,
      S_DIV,
      S_MUL,
      S_ACC,
      S_DONE
   } state_type;

   state_type                          state_ff, state_in;
   logic [kli_pkg::IDX_W-1:0]          chk_ff, chk_in;
   logic [kli_pkg::STEP_W-1:0]         step_ff, step_in;
   logic [kli_pkg::ATOM_IDX_W-1:0]     atom_ff, atom_in;
   kli_pkg::out_sel_type               sel_ff, sel_in;
   kli_pkg::status_type                status_ff, status_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [kli_pkg::PCOUNT_W-1:0]       point_count_ff, point_count_in;

   logic [kli_pkg::CNT_W-1:0]          n;
   logic [kli_pkg::CNT_W-1:0]          n_m1;
   logic                               last;

   // counts above the table depth use the whole table
   always_comb begin
      if (int'(point_count_ff) > kli_pkg::MAX_POINTS) begin
         n = kli_pkg::CNT_W'(kli_pkg::MAX_POINTS);
      end else begin
         n = kli_pkg::CNT_W'(point_count_ff);
      end
   end

   assign n_m1 = n - kli_pkg::CNT_W'(1);
   assign last = (kli_pkg::CNT_W'(chk_ff) == n_m1);

   assign req_ready    = (state_ff == S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign csr_if.ready = 1'b1;

   always_comb begin
      state_in       = state_ff;
      chk_in         = chk_ff;
      step_in        = step_ff;
      atom_in        = atom_ff;
      sel_in         = sel_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      point_count_in = point_count_ff;

      cmd            = '0;
      cmd.rd_addr    = chk_ff + kli_pkg::IDX_W'(1);
      cmd.atom_sel   = atom_ff;
      cmd.out_sel    = sel_ff;
      cmd.out_status = status_ff;

      if (csr_if.valid) begin
         unique case (csr_if.index)
            kli_pkg::CSR_POINT_COUNT: begin
               point_count_in = csr_if.data[kli_pkg::PCOUNT_W-1:0];
            end
            // atom format needs no storage: both formats truncate alike
            kli_pkg::CSR_ATOM_IS_INT: begin
            end
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_func == kli_pkg::FUNC_WRITE) begin
                  cmd.wr_en = 1'b1;
               end else begin
                  cmd.load_query = 1'b1;
                  if (n == '0) begin
                     sel_in    = kli_pkg::SEL_ZERO;
                     status_in = kli_pkg::ST_EMPTY;
                     state_in  = S_DONE;
                  end else begin
                     cmd.rd_en   = 1'b1;
                     cmd.rd_addr = '0;
                     chk_in      = '0;
                     state_in    = S_SCAN;
                  end
               end
            end
         end
         // one keyframe checked per cycle, next one read alongside
         S_SCAN: begin
            cmd.load_cur = 1'b1;
            cmd.rd_en    = 1'b1;
            if (stat.later) begin
               if (chk_ff == '0) begin
                  sel_in    = kli_pkg::SEL_END;
                  status_in = kli_pkg::ST_BEFORE;
                  state_in  = S_DONE;
               end else if (stat.prev_hold) begin
                  sel_in    = kli_pkg::SEL_START;
                  status_in = kli_pkg::ST_HOLD;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_DIV_INIT;
               end
            end else if (last) begin
               sel_in    = kli_pkg::SEL_END;
               status_in = kli_pkg::ST_AFTER;
               state_in  = S_DONE;
            end else begin
               cmd.load_prev = 1'b1;
               chk_in        = chk_ff + kli_pkg::IDX_W'(1);
            end
         end
         S_DIV_INIT: begin
            cmd.div_init = 1'b1;
            step_in      = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == kli_pkg::STEP_W'(kli_pkg::WEIGHT_BITS - 1)) begin
               atom_in  = '0;
               state_in = S_MUL;
            end else begin
               step_in = step_ff + kli_pkg::STEP_W'(1);
            end
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_ACC;
         end
         S_ACC: begin
            cmd.acc_en = 1'b1;
            if (atom_ff == kli_pkg::ATOM_IDX_W'(kli_pkg::ATOMS - 1)) begin
               sel_in    = kli_pkg::SEL_WORK;
               status_in = kli_pkg::ST_INTERP;
               state_in  = S_DONE;
            end else begin
               atom_in  = atom_ff + kli_pkg::ATOM_IDX_W'(1);
               state_in = S_MUL;
            end
         end
         // wait for the output register to free up
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         chk_ff         <= '0;
         step_ff        <= '0;
         atom_ff        <= '0;
         sel_ff         <= kli_pkg::SEL_ZERO;
         status_ff      <= kli_pkg::ST_EMPTY;
         rsp_valid_ff   <= 1'b0;
         point_count_ff <= '0;
      end else begin
         state_ff       <= state_in;
         chk_ff         <= chk_in;
         step_ff        <= step_in;
         atom_ff        <= atom_in;
         sel_ff         <= sel_in;
         status_ff      <= status_in;
         rsp_valid_ff   <= rsp_valid_in;
         point_count_ff <= point_count_in;
      end
   end

   `KLI_ASSERT_IMPL(a_out_reg_free, clock, reset, cmd.out_load, !rsp_valid_ff || rsp_ready, "response overwritten before taken")
   `KLI_ASSERT_IMPL(a_scan_in_range, clock, reset, state_ff == S_SCAN, kli_pkg::CNT_W'(chk_ff) < n, "scan beyond point count")
   `KLI_ASSERT_IMPL(a_div_before_blend, clock, reset, state_ff == S_MUL && atom_ff == '0, $past(state_ff) == S_DIV, "blend started without weight")
   `KLI_ASSERT_NEXT(a_query_starts_scan, clock, reset, state_ff == S_IDLE && req_valid && req_func == kli_pkg::FUNC_QUERY && n != '0, state_ff == S_SCAN && chk_ff == '0, "query did not start at first keyframe")

endmodule

>>> hw/rtl/kli_datapath.sv
// ----------------------------------------------------------------------------
// Keyframe interpolator datapath
// Keyframe table RAM, scan registers, restoring weight divider, shared
// blend multiplier and the response register.
// ----------------------------------------------------------------------------
module kli_datapath (
   input  logic                                              clock,
   input  kli_pkg::req_payload_type                          req_pl,
   input  kli_pkg::dp_cmd_type                               cmd,
   output kli_pkg::dp_stat_type                              stat,
   output logic [kli_pkg::ATOM_FIELDS-1:0][kli_pkg::ATOM_W-1:0] rsp_atoms,
   output kli_pkg::status_type                               rsp_status
);

   localparam logic signed [kli_pkg::SUM_W-1:0] ROUND_BIAS =
      kli_pkg::SUM_W'((1 << kli_pkg::WEIGHT_BITS) - 1);

   kli_pkg::row_type                         wr_row;
   kli_pkg::row_type                         rd_row;
   logic                                     slot_ok;

   logic [kli_pkg::TIME_W-1:0]               qt_ff;
   kli_pkg::row_type                         prev_ff;
   kli_pkg::row_type                         cur_ff;

   logic [kli_pkg::TIME_W-1:0]               rem_ff, rem_in;
   logic [kli_pkg::TIME_W-1:0]               den_ff;
   logic [kli_pkg::WEIGHT_BITS-1:0]          quo_ff, quo_in;
   logic [kli_pkg::TIME_W:0]                 rem_sh;
   logic [kli_pkg::TIME_W:0]                 rem_sub;
   logic                                     rem_ge;

   logic signed [kli_pkg::ATOM_W-1:0]        s_atom;
   logic signed [kli_pkg::ATOM_W-1:0]        e_atom;
   logic signed [kli_pkg::DIFF_W-1:0]        d_atom;
   logic signed [kli_pkg::WEIGHT_BITS:0]     w_s;
   logic signed [kli_pkg::PROD_W-1:0]        prod_ff, prod_in;
   logic signed [kli_pkg::SUM_W-1:0]         base;
   logic signed [kli_pkg::SUM_W-1:0]         sum;
   logic signed [kli_pkg::SUM_W-1:0]         adj;
   logic signed [kli_pkg::SUM_W-1:0]         shifted;
   logic [kli_pkg::ATOMS-1:0][kli_pkg::ATOM_W-1:0] work_ff;

   logic [kli_pkg::ATOM_FIELDS-1:0][kli_pkg::ATOM_W-1:0] out_atoms_ff, out_atoms_in;
   kli_pkg::status_type                      out_status_ff;

   // keyframe table, one row per slot
   always_comb begin
      wr_row.tstamp = req_pl.point_time;
      wr_row.hold   = req_pl.point_mode;
      for (int a = 0; a < kli_pkg::ATOMS; a++) begin
         wr_row.atoms[a] = req_pl.atoms[a];
      end
   end

   assign slot_ok = (int'(req_pl.point_index) < kli_pkg::MAX_POINTS);

   kli_ram #(
      .WIDTH ($bits(kli_pkg::row_type)),
      .DEPTH (kli_pkg::MAX_POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.wr_en && slot_ok),
      .wr_addr (kli_pkg::IDX_W'(req_pl.point_index)),
      .wr_data (wr_row),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (rd_row)
   );

   assign stat.later     = (rd_row.tstamp > qt_ff);
   assign stat.prev_hold = prev_ff.hold;

   // restoring division, one quotient bit a cycle; remainder stays below den
   assign rem_sh  = {rem_ff, 1'b0};
   assign rem_ge  = (rem_sh >= {1'b0, den_ff});
   assign rem_sub = rem_sh - {1'b0, den_ff};
   assign rem_in  = rem_ge ? rem_sub[kli_pkg::TIME_W-1:0] : rem_sh[kli_pkg::TIME_W-1:0];
   assign quo_in  = {quo_ff[kli_pkg::WEIGHT_BITS-2:0], rem_ge};

   // start*(1-w) + end*w rewritten as start*one + (end-start)*w
   assign s_atom  = prev_ff.atoms[cmd.atom_sel];
   assign e_atom  = cur_ff.atoms[cmd.atom_sel];
   assign d_atom  = {e_atom[kli_pkg::ATOM_W-1], e_atom} - {s_atom[kli_pkg::ATOM_W-1], s_atom};
   assign w_s     = {1'b0, quo_ff};
   assign prod_in = d_atom * w_s;

   assign base    = {{(kli_pkg::SUM_W - kli_pkg::ATOM_W - kli_pkg::WEIGHT_BITS)
                      {s_atom[kli_pkg::ATOM_W-1]}},
                     s_atom, {kli_pkg::WEIGHT_BITS{1'b0}}};
   assign sum     = base + kli_pkg::SUM_W'(prod_ff);
   // bias negatives so the shift truncates toward zero
   assign adj     = sum + (sum[kli_pkg::SUM_W-1] ? ROUND_BIAS : '0);
   assign shifted = adj >>> kli_pkg::WEIGHT_BITS;

   always_comb begin
      out_atoms_in = '0;
      for (int a = 0; a < kli_pkg::ATOM_FIELDS; a++) begin
         if (a < kli_pkg::ATOMS) begin
            unique case (cmd.out_sel)
               kli_pkg::SEL_ZERO:  out_atoms_in[a] = '0;
               kli_pkg::SEL_START: out_atoms_in[a] = prev_ff.atoms[a];
               kli_pkg::SEL_END:   out_atoms_in[a] = cur_ff.atoms[a];
               kli_pkg::SEL_WORK:  out_atoms_in[a] = work_ff[a];
               default:            out_atoms_in[a] = '0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         qt_ff <= req_pl.query_time;
      end
      if (cmd.load_prev) begin
         prev_ff <= rd_row;
      end
      if (cmd.load_cur) begin
         cur_ff <= rd_row;
      end
      if (cmd.div_init) begin
         rem_ff <= qt_ff - prev_ff.tstamp;
         den_ff <= cur_ff.tstamp - prev_ff.tstamp;
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.acc_en) begin
         work_ff[cmd.atom_sel] <= shifted[kli_pkg::ATOM_W-1:0];
      end
      if (cmd.out_load) begin
         out_atoms_ff  <= out_atoms_in;
         out_status_ff <= cmd.out_status;
      end
   end

   assign rsp_atoms  = out_atoms_ff;
   assign rsp_status = out_status_ff;

endmodule

>>> hw/rtl/keyframe_linear_interpolator.sv
// ----------------------------------------------------------------------------
// Keyframe linear interpolator
// Keyframe table with piecewise linear or held lookup at a query time.
// ----------------------------------------------------------------------------
// A keyframe write request is taken in the idle state. A query request on an
// empty table goes straight to the response; otherwise it scans the keyframes,
// at most point_count of them (capped at the 64-slot table), and ends in hold,
// before-first or after-last, or else divides for the 16-bit weight and blends
// each of the 4 atoms. The scan reads one keyframe a cycle from the
// single-read-port table RAM, the divider produces one weight bit a cycle,
// and the shared multiplier works one atom at a time. One query is worked at
// a time; a finished response sits in an output register, so the next
// request is taken while it waits.
module keyframe_linear_interpolator (
   input  logic       clock,
   input  logic       reset,
   kli_req_if.sink    req_if,
   kli_rsp_if.source  rsp_if,
   kli_csr_if.sink    csr_if
);

   kli_pkg::req_payload_type req_pl;
   kli_pkg::dp_cmd_type      cmd;
   kli_pkg::dp_stat_type     stat;
   kli_pkg::status_type      rsp_status;
   logic [kli_pkg::ATOM_FIELDS-1:0][kli_pkg::ATOM_W-1:0] rsp_atoms;

   always_comb begin
      req_pl.func        = req_if.func;
      req_pl.point_index = req_if.point_index;
      req_pl.point_time  = req_if.point_time;
      req_pl.point_mode  = req_if.point_mode;
      req_pl.atoms[0]    = req_if.atom_in0;
      req_pl.atoms[1]    = req_if.atom_in1;
      req_pl.atoms[2]    = req_if.atom_in2;
      req_pl.atoms[3]    = req_if.atom_in3;
      req_pl.query_time  = req_if.query_time;
   end

   kli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_func  (req_if.func),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .csr_if    (csr_if),
      .stat      (stat),
      .cmd       (cmd)
   );

   kli_datapath u_datapath (
      .clock      (clock),
      .req_pl     (req_pl),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_atoms  (rsp_atoms),
      .rsp_status (rsp_status)
   );

   assign rsp_if.atom_out0 = rsp_atoms[0];
   assign rsp_if.atom_out1 = rsp_atoms[1];
   assign rsp_if.atom_out2 = rsp_atoms[2];
   assign rsp_if.atom_out3 = rsp_atoms[3];
   assign rsp_if.status    = rsp_status;

endmodule

>>> test/tb_keyframe_linear_interpolator.sv
// ----------------------------------------------------------------------------
// Keyframe linear interpolator testbench
// Keyframe writes and value queries go in through the request channel under
// random idling and back-pressure. A private copy of the keyframe table gives
// the expected atoms and status of each query, and every response is checked
// in order against them.
// ----------------------------------------------------------------------------
module tb_keyframe_linear_interpolator;
   timeunit 1ns;
   timeprecision 1ps;

   import kli_pkg::*;

   localparam logic MODE_LINEAR = 1'b0;
   localparam logic MODE_HOLD   = 1'b1;

   // register indexes with nothing behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_TOP   = CSR_IDX_W'(15);

   localparam int     PHASES        = 9;
   localparam int     RANDOM_ITEMS  = 110;
   localparam int     SETTLE_CYCLES = 8;
   localparam int     DRAIN_CYCLES  = 100;
   localparam int     STALL_LIMIT   = 5000;
   localparam int     HOLD_OFF_LEN  = 400;
   localparam longint TIME_CEIL     = 64'hFFFF_FFFF;

   localparam logic [CSR_DATA_W-1:0] COUNT_PLAN [PHASES] =
      '{8'd1, 8'd2, 8'd7, 8'd64, 8'd127, 8'h85, 8'd16, 8'd0, 8'd3};
   localparam logic [CSR_DATA_W-1:0] FORMAT_PLAN [PHASES] =
      '{8'h00, 8'h05, 8'h0A, 8'h0F, 8'h03, 8'hF0, 8'h0C, 8'h09, 8'h06};
   localparam logic [TIME_W-1:0] PROBE_TIMES [10] =
      '{32'd0, 32'd99, 32'd100, 32'd150, 32'd199, 32'd200, 32'd250, 32'd300,
        32'hFFFF_FFFE, 32'hFFFF_FFFF};

   typedef struct {
      logic signed [ATOM_W-1:0] atom [ATOM_FIELDS];
      logic [STATUS_W-1:0]      status;
   } lookup_result_type;

   // Keyframe table copy and the queue of query results still owed
   class interp_tracker;
      logic [TIME_W-1:0]        key_time [MAX_POINTS];
      logic                     key_hold [MAX_POINTS];
      logic signed [ATOM_W-1:0] key_atom [MAX_POINTS][ATOM_FIELDS];
      logic [PCOUNT_W-1:0]      point_count;
      logic [3:0]               atom_is_int;
      lookup_result_type        awaited [$];
      int                       errors;

      function new();
         point_count = '0;
         atom_is_int = '0;
         errors      = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_POINT_COUNT)
            point_count = value[PCOUNT_W-1:0];
         else if (idx == CSR_ATOM_IS_INT)
            atom_is_int = value[3:0];
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function lookup_result_type slot_result(int slot, logic [STATUS_W-1:0] code);
         lookup_result_type res;
         int a;
         for (a = 0; a < ATOM_FIELDS; a++)
            res.atom[a] = key_atom[slot][a];
         res.status = code;
         return res;
      endfunction

      function lookup_result_type lookup(logic [TIME_W-1:0] qt);
         lookup_result_type res;
         int                in_use, later, first, i, a;
         bit                found;
         logic [TIME_W-1:0] elapsed, span;
         logic [63:0]       scaled;
         longint            weight, unity, s, e, mix;
         for (a = 0; a < ATOM_FIELDS; a++)
            res.atom[a] = '0;
         res.status = ST_EMPTY;
         in_use = (point_count > MAX_POINTS) ? MAX_POINTS : point_count;
         if (in_use == 0)
            return res;
         found = 1'b0;
         later = 0;
         for (i = 0; i < in_use && !found; i++) begin
            if (key_time[i] > qt) begin
               found = 1'b1;
               later = i;
            end
         end
         if (!found)
            return slot_result(in_use - 1, ST_AFTER);
         if (later == 0)
            return slot_result(0, ST_BEFORE);
         first = later - 1;
         if (key_hold[first])
            return slot_result(first, ST_HOLD);
         // earlier key never lies after qt, so the span is never zero
         elapsed = qt - key_time[first];
         span    = key_time[later] - key_time[first];
         scaled  = {32'd0, elapsed};
         scaled  = scaled << WEIGHT_BITS;
         scaled  = scaled / {32'd0, span};
         weight  = longint'(scaled);
         unity   = longint'(1) << WEIGHT_BITS;
         for (a = 0; a < ATOM_FIELDS; a++) begin
            s   = key_atom[first][a];
            e   = key_atom[later][a];
            mix = (s * (unity - weight) + e * weight) / unity;
            res.atom[a] = ATOM_W'(mix);
         end
         res.status = ST_INTERP;
         return res;
      endfunction

      function void absorb_request(req_payload_type r);
         int a;
         if (r.func == FUNC_WRITE) begin
            key_time[r.point_index] = r.point_time;
            key_hold[r.point_index] = r.point_mode;
            for (a = 0; a < ATOM_FIELDS; a++)
               key_atom[r.point_index][a] = r.atoms[a];
         end else begin
            awaited.push_back(lookup(r.query_time));
         end
      endfunction

      function void check_outcome(lookup_result_type got);
         lookup_result_type want;
         int a;
         if (awaited.size() == 0) begin
            $error("response with no query outstanding, status %0d", got.status);
            errors++;
            return;
         end
         want = awaited.pop_front();
         for (a = 0; a < ATOM_FIELDS; a++) begin
            if (got.atom[a] !== want.atom[a]) begin
               $error("atom_out%0d: expected %0d, got %0d", a, want.atom[a], got.atom[a]);
               errors++;
            end
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   kli_req_if req_if ();
   kli_rsp_if rsp_if ();
   kli_csr_if csr_if ();

   keyframe_linear_interpolator DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   interp_tracker     tracker = new();
   lookup_result_type seen;
   int                req_idle_pct = 15;
   int                rsp_idle_pct = 76;
   int                hold_off     = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // response side: idles at random, or holds off for a counted stretch
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            rsp_if.ready = 1'b0;
            hold_off--;
         end else begin
            rsp_if.ready = ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         seen.atom[0] = rsp_if.atom_out0;
         seen.atom[1] = rsp_if.atom_out1;
         seen.atom[2] = rsp_if.atom_out2;
         seen.atom[3] = rsp_if.atom_out3;
         seen.status  = rsp_if.status;
         tracker.check_outcome(seen);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Mismatches found");
      $finish;
   end

   function automatic logic signed [ATOM_W-1:0] random_atom();
      case ($urandom_range(5))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return $urandom_range(16) - 8;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_payload_type make_write(
      input logic [SLOT_W-1:0]        slot,
      input logic [TIME_W-1:0]        stamp,
      input logic                     hold,
      input logic signed [ATOM_W-1:0] a0, a1, a2, a3
   );
      req_payload_type r;
      r.func        = FUNC_WRITE;
      r.point_index = slot;
      r.point_time  = stamp;
      r.point_mode  = hold;
      r.atoms[0]    = a0;
      r.atoms[1]    = a1;
      r.atoms[2]    = a2;
      r.atoms[3]    = a3;
      r.query_time  = $urandom;
      return r;
   endfunction

   // write fields of a query carry junk; the block must ignore them
   function automatic req_payload_type make_query(input logic [TIME_W-1:0] qt);
      req_payload_type r;
      r.func        = FUNC_QUERY;
      r.point_index = $urandom;
      r.point_time  = $urandom;
      r.point_mode  = $urandom;
      r.atoms[0]    = $urandom;
      r.atoms[1]    = $urandom;
      r.atoms[2]    = $urandom;
      r.atoms[3]    = $urandom;
      r.query_time  = qt;
      return r;
   endfunction

   task automatic push_request(input req_payload_type r);
      while ($urandom_range(99) < req_idle_pct) begin
         @(negedge clock);
         req_if.valid = 1'b0;
      end
      @(negedge clock);
      req_if.func        = r.func;
      req_if.point_index = r.point_index;
      req_if.point_time  = r.point_time;
      req_if.point_mode  = r.point_mode;
      req_if.atom_in0    = r.atoms[0];
      req_if.atom_in1    = r.atoms[1];
      req_if.atom_in2    = r.atoms[2];
      req_if.atom_in3    = r.atoms[3];
      req_if.query_time  = r.query_time;
      req_if.valid       = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      tracker.absorb_request(r);
   endtask

   task automatic set_register(input logic [CSR_IDX_W-1:0] idx,
                               input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_if.index = idx;
      csr_if.data  = value;
      csr_if.valid = 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      tracker.write_register(idx, value);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   // all responses in, then room for a trailing keyframe write to finish
   task automatic settle_block();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int                    p, k, n, slot;
      int unsigned           scale;
      longint                stamp;
      logic [TIME_W-1:0]     lo, hi, t;
      logic                  hold;

      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.func        = FUNC_WRITE;
      req_if.point_index = '0;
      req_if.point_time  = '0;
      req_if.point_mode  = MODE_LINEAR;
      req_if.atom_in0    = '0;
      req_if.atom_in1    = '0;
      req_if.atom_in2    = '0;
      req_if.atom_in3    = '0;
      req_if.query_time  = '0;
      csr_if.valid       = 1'b0;
      csr_if.index       = CSR_POINT_COUNT;
      csr_if.data        = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty table straight after reset
      push_request(make_query(32'd0));
      push_request(make_query(32'hFFFF_FFFF));

      // linear, hold, linear, then a last key at the end of time
      push_request(make_write(0, 32'd100, MODE_LINEAR,
                              32'sh7FFF_FFFF, 32'sh8000_0000, -1, 0));
      push_request(make_write(1, 32'd200, MODE_HOLD,
                              32'sh8000_0000, 32'sh7FFF_FFFF, 2, -3));
      push_request(make_write(2, 32'd300, MODE_LINEAR,
                              -7, 7, 32'sh7FFF_FFFF, 32'sh8000_0000));
      push_request(make_write(3, 32'hFFFF_FFFF, MODE_LINEAR,
                              5, -5, 32'sh8000_0000, 32'sh7FFF_FFFF));
      settle_block();
      set_register(CSR_POINT_COUNT, 8'd4);
      set_register(CSR_ATOM_IS_INT, 8'h0F);
      set_register(CSR_TOP, 8'hFF);
      for (k = 0; k < 10; k++)
         push_request(make_query(PROBE_TIMES[k]));

      for (p = 0; p < PHASES; p++) begin
         settle_block();
         req_idle_pct = (p < 3) ? 15 : (p < 6) ? 76 : 0;
         rsp_idle_pct = (p < 3) ? 76 : (p < 6) ? 15 : 0;
         set_register(CSR_POINT_COUNT, COUNT_PLAN[p]);
         set_register(CSR_ATOM_IS_INT, FORMAT_PLAN[p]);
         if (p == 2)
            set_register(CSR_SPARE, $urandom);

         n = COUNT_PLAN[p][PCOUNT_W-1:0];
         if (n > MAX_POINTS)
            n = MAX_POINTS;

         // non-decreasing keyframes over every slot in use
         case ($urandom_range(2))
            0:       scale = 4;
            1:       scale = 2000;
            default: scale = 60_000_000;
         endcase
         stamp = (n <= 2) ? longint'($urandom) : longint'($urandom_range(4 * scale, 0));
         for (k = 0; k < n; k++) begin
            if (stamp > TIME_CEIL)
               stamp = TIME_CEIL;
            hold = ($urandom_range(3) == 0) ? MODE_HOLD : MODE_LINEAR;
            push_request(make_write(k, TIME_W'(stamp), hold, random_atom(), random_atom(),
                                    random_atom(), random_atom()));
            stamp += $urandom_range(scale, 0);
         end

         // output stalled long enough for the request side to back up
         if (p == 6)
            hold_off = HOLD_OFF_LEN;

         for (k = 0; k < RANDOM_ITEMS; k++) begin
            if ($urandom_range(3) == 0) begin
               if (n > 0 && $urandom_range(9) < 7) begin
                  // keep the order of times across slots
                  slot = $urandom_range(n - 1);
                  lo   = (slot == 0) ? '0 : tracker.key_time[slot - 1];
                  hi   = (slot == n - 1) ? '1 : tracker.key_time[slot + 1];
                  t    = $urandom_range(hi, lo);
               end else begin
                  slot = $urandom_range(MAX_POINTS - 1);
                  t    = $urandom;
               end
               hold = ($urandom_range(3) == 0) ? MODE_HOLD : MODE_LINEAR;
               push_request(make_write(slot, t, hold, random_atom(), random_atom(),
                                       random_atom(), random_atom()));
            end else begin
               if (n == 0 || $urandom_range(5) == 0) begin
                  t = $urandom;
               end else begin
                  slot = $urandom_range(n - 1);
                  hi   = (slot == n - 1) ? '1 : tracker.key_time[slot + 1];
                  case ($urandom_range(4))
                     0:       t = tracker.key_time[slot] - 1;
                     1:       t = tracker.key_time[slot];
                     2:       t = tracker.key_time[slot] + 1;
                     default: t = $urandom_range(hi, tracker.key_time[slot]);
                  endcase
               end
               push_request(make_query(t));
            end
         end
      end

      settle_block();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/kli_pkg.sv
hw/rtl/kli_req_if.sv
hw/rtl/kli_rsp_if.sv
hw/rtl/kli_csr_if.sv
hw/rtl/kli_ram.sv
hw/rtl/kli_ctrl.sv
hw/rtl/kli_datapath.sv
hw/rtl/keyframe_linear_interpolator.sv
test/tb_keyframe_linear_interpolator.sv
